// ----- sv/gbr_pkg.sv -----
// Shared types and constants for the clipped glyph row blitter.
// Used by every module of the block; depends on nothing.
`default_nettype none
package gbr_pkg;

  localparam int GlyphSize  = 8;
  localparam int RowBits    = 8;
  localparam int GlyphCols  = (GlyphSize < RowBits) ? GlyphSize : RowBits;
  localparam int CoordLimit = 2048;
  localparam int CfgW       = 12;
  localparam int CoordW     = 12;
  localparam int PixW       = 11;
  localparam int ColorW     = 32;
  localparam int RowIdxW    = 3;
  localparam int ColW       = $clog2(RowBits);
  localparam int XSpan      = 2 * RowBits;
  localparam int XOffW      = $clog2(XSpan);
  localparam int MaskW      = 4 * RowBits;
  localparam int SlotW      = $clog2(MaskW);
  localparam int YBaseW     = CoordW + 2;
  localparam int FifoDepth  = 2;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [CfgW-1:0] WidthReset  = CfgW'(640);
  localparam logic [CfgW-1:0] HeightReset = CfgW'(480);

  typedef enum logic [0:0] {
    CfgScreenWidth  = 1'b0,
    CfgScreenHeight = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                     mode;
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic [RowIdxW-1:0]       row_index;
    logic [RowBits-1:0]       glyph_row_bits;
    logic [ColorW-1:0]        fg_color;
    logic [ColorW-1:0]        bg_color;
  } glyph_in_t;

  typedef struct packed {
    logic [PixW-1:0]   pixel_x;
    logic [PixW-1:0]   pixel_y;
    logic [ColorW-1:0] pixel_color;
    logic              last;
  } pixel_out_t;

  // One classified row: visible-slot mask in emission order plus what the
  // back end needs to rebuild each pixel.
  typedef struct packed {
    logic                     mode;
    logic signed [CoordW-1:0] base_x;
    logic [YBaseW-1:0]        base_y;
    logic [MaskW-1:0]         mask;
    logic [RowBits-1:0]       bits;
    logic [ColorW-1:0]        fg_color;
    logic [ColorW-1:0]        bg_color;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/clipped_glyph_row_blit.sv -----
// A row's first pixel beat passes the queue, the emitter's job and mask
// registers and the registered output stage. The emitter gives one pixel
// beat per cycle unless the output stalls, one per visible pixel of a row
// (0 to 32, at most 8 in 1x mode); fully clipped rows take no emitter time.
// A 2-entry queue takes rows while the emitter is busy. Reset (async, active
// low) empties the queue and output stage and sets the screen to 640 x 480.
`default_nettype none
module clipped_glyph_row_blit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [0:0]                cfg_idx_i,
  input  wire logic [gbr_pkg::CfgW-1:0]  cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire gbr_pkg::glyph_in_t        in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output gbr_pkg::pixel_out_t            out_item_o
);

  logic          q_push, q_full, q_pop, q_avail;
  gbr_pkg::job_t q_wdata, q_rdata;

  gbr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  gbr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .avail_o     (q_avail),
    .pop_data_o  (q_rdata)
  );

  gbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_avail_i   (q_avail),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ----- sv/gbr_fifo.sv -----
// Small job queue between the classifier and the pixel emitter.
// Depends on gbr_pkg for the job type and depth.
`default_nettype none
module gbr_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire gbr_pkg::job_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               avail_o,
  output gbr_pkg::job_t      pop_data_o
);

  gbr_pkg::job_t                   mem_q [gbr_pkg::FifoDepth];
  logic [gbr_pkg::FifoPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [gbr_pkg::FifoPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [gbr_pkg::FifoCntW-1:0]    count_q, count_d;

  assign full_o     = (count_q == gbr_pkg::FifoCntW'(gbr_pkg::FifoDepth));
  assign avail_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == gbr_pkg::FifoPtrW'(gbr_pkg::FifoDepth - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == gbr_pkg::FifoPtrW'(gbr_pkg::FifoDepth - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/gbr_front.sv -----
// Front end: screen size registers, input handshake and per-row clipping.
// Builds a mask of visible pixel slots; fully clipped rows are dropped here.
// Depends on gbr_pkg.
`default_nettype none
module gbr_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [0:0]                cfg_idx_i,
  input  wire logic [gbr_pkg::CfgW-1:0]  cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire gbr_pkg::glyph_in_t        in_item_i,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output gbr_pkg::job_t                  q_data_o
);

  localparam int CmpW = gbr_pkg::CoordW + 2;

  logic [gbr_pkg::CfgW-1:0]  width_q, height_q;
  logic [gbr_pkg::CfgW-1:0]  width_eff, height_eff;
  logic [CmpW-1:0]           px  [gbr_pkg::XSpan];
  logic [gbr_pkg::XSpan-1:0] xvis;
  logic [CmpW-1:0]           py  [2];
  logic [1:0]                yvis;
  logic [gbr_pkg::YBaseW-1:0] row_off;
  logic [gbr_pkg::YBaseW-1:0] base_y;
  logic [gbr_pkg::MaskW-1:0] mask;
  logic                      row_in_glyph;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gbr_pkg::WidthReset;
      height_q <= gbr_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (gbr_pkg::cfg_idx_e'(cfg_idx_i))
        gbr_pkg::CfgScreenWidth:  width_q  <= cfg_wdata_i;
        gbr_pkg::CfgScreenHeight: height_q <= cfg_wdata_i;
      endcase
    end
  end

  assign width_eff  = (width_q > gbr_pkg::CfgW'(gbr_pkg::CoordLimit))
                      ? gbr_pkg::CfgW'(gbr_pkg::CoordLimit) : width_q;
  assign height_eff = (height_q > gbr_pkg::CfgW'(gbr_pkg::CoordLimit))
                      ? gbr_pkg::CfgW'(gbr_pkg::CoordLimit) : height_q;

  // Column k is the pixel offset from origin_x, 0..2*RowBits-1.
  always_comb begin
    for (int k = 0; k < gbr_pkg::XSpan; k++) begin
      px[k]   = CmpW'(in_item_i.origin_x) + CmpW'(k);
      xvis[k] = !px[k][CmpW-1] && (px[k] < CmpW'(width_eff));
    end
  end

  assign row_off = in_item_i.mode ? gbr_pkg::YBaseW'({in_item_i.row_index, 1'b0})
                                  : gbr_pkg::YBaseW'(in_item_i.row_index);
  assign base_y  = gbr_pkg::YBaseW'(in_item_i.origin_y) + row_off;

  always_comb begin
    for (int d = 0; d < 2; d++) begin
      py[d]   = CmpW'(base_y) + CmpW'(d);
      yvis[d] = !py[d][CmpW-1] && (py[d] < CmpW'(height_eff));
    end
  end

  assign row_in_glyph = (32'(in_item_i.row_index) < gbr_pkg::GlyphSize);

  // Slot order: 1x slot j; 2x slot 4j + 2dy + dx.
  always_comb begin
    mask = '0;
    for (int j = 0; j < gbr_pkg::GlyphCols; j++) begin
      if (in_item_i.mode) begin
        for (int dy = 0; dy < 2; dy++) begin
          for (int dx = 0; dx < 2; dx++) begin
            mask[4*j + 2*dy + dx] = yvis[dy] && xvis[2*j + dx];
          end
        end
      end else begin
        mask[j] = yvis[0] && xvis[j];
      end
    end
    if (!row_in_glyph) begin
      mask = '0;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && (mask != '0);

  always_comb begin
    q_data_o          = '0;
    q_data_o.mode     = in_item_i.mode;
    q_data_o.base_x   = in_item_i.origin_x;
    q_data_o.base_y   = base_y;
    q_data_o.mask     = mask;
    q_data_o.bits     = in_item_i.glyph_row_bits;
    q_data_o.fg_color = in_item_i.fg_color;
    q_data_o.bg_color = in_item_i.bg_color;
  end

endmodule
`default_nettype wire

// ----- sv/gbr_back.sv -----
// Back end: walks one row's visible-slot mask, one pixel beat a cycle unless
// stalled, into a registered output stage. Loads the next queued row without
// a bubble. Depends on gbr_pkg.
`default_nettype none
module gbr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_avail_i,
  input  wire gbr_pkg::job_t q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output gbr_pkg::pixel_out_t out_item_o
);

  gbr_pkg::job_t              job_q;
  logic [gbr_pkg::MaskW-1:0]  mask_q, mask_d;
  logic                       out_valid_q, out_valid_d;
  gbr_pkg::pixel_out_t        out_item_q, out_item_d;

  logic                       adv, active, emit, load;
  logic [gbr_pkg::SlotW-1:0]  slot;
  logic [gbr_pkg::MaskW-1:0]  rest;
  logic [gbr_pkg::ColW-1:0]   col;
  logic                       dx, dy;
  logic [gbr_pkg::XOffW-1:0]  xoff;
  logic [gbr_pkg::CoordW-1:0] xsum;
  logic [gbr_pkg::YBaseW-1:0] ysum;

  assign adv    = !out_valid_q || out_ready_i;
  assign active = (mask_q != '0);
  assign emit   = adv && active;

  // lowest set slot first
  always_comb begin
    slot = '0;
    for (int i = gbr_pkg::MaskW - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        slot = gbr_pkg::SlotW'(i);
      end
    end
  end

  always_comb begin
    rest       = mask_q;
    rest[slot] = 1'b0;
  end

  assign col  = job_q.mode ? slot[gbr_pkg::ColW+1:2] : slot[gbr_pkg::ColW-1:0];
  assign dx   = job_q.mode && slot[0];
  assign dy   = job_q.mode && slot[1];
  assign xoff = job_q.mode ? gbr_pkg::XOffW'({col, dx}) : gbr_pkg::XOffW'(col);
  assign xsum = job_q.base_x + gbr_pkg::CoordW'(xoff);
  assign ysum = job_q.base_y + gbr_pkg::YBaseW'(dy);

  assign load    = q_avail_i && (!active || (emit && (rest == '0)));
  assign q_pop_o = load;

  always_comb begin
    mask_d = emit ? rest : mask_q;
    if (load) begin
      mask_d = q_data_i.mask;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (adv) begin
      out_valid_d             = active;
      out_item_d.pixel_x      = xsum[gbr_pkg::PixW-1:0];
      out_item_d.pixel_y      = ysum[gbr_pkg::PixW-1:0];
      out_item_d.pixel_color  = job_q.bits[gbr_pkg::ColW'(gbr_pkg::RowBits - 1) - col]
                                ? job_q.fg_color : job_q.bg_color;
      out_item_d.last         = (rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= q_data_i;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

// ----- sv/gbr_checker.sv -----
// Port-level checks for clipped_glyph_row_blit, bound to the top level.
// Shadows the screen size from the config port; depends on gbr_pkg.
`default_nettype none
module gbr_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      cfg_we_i,
  input wire logic [0:0]                cfg_idx_i,
  input wire logic [gbr_pkg::CfgW-1:0]  cfg_wdata_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire gbr_pkg::pixel_out_t       out_item_o
);

  logic [gbr_pkg::CfgW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gbr_pkg::WidthReset;
      height_q <= gbr_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (gbr_pkg::cfg_idx_e'(cfg_idx_i))
        gbr_pkg::CfgScreenWidth:  width_q  <= cfg_wdata_i;
        gbr_pkg::CfgScreenHeight: height_q <= cfg_wdata_i;
      endcase
    end
  end

  // the output stage is cleared asynchronously while reset is low
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output beat valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled pixel beat changed");

  a_x_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gbr_pkg::CfgW'(out_item_o.pixel_x) < width_q))
    else $error("pixel beyond screen width");

  a_y_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gbr_pkg::CfgW'(out_item_o.pixel_y) < height_q))
    else $error("pixel beyond screen height");

endmodule

bind clipped_glyph_row_blit gbr_checker u_gbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire
